// ===== hdl/smpq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the sorted minimum priority queue.
// ---------------------------------------------------------------------------
package smpq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int KEY_W            = 32;
  localparam int COUNT_W          = 5;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic    in_ready;
    logic    load;
    logic    rd_prev;
    logic    rd_head;
    logic    shift;
    logic    place;
    logic    pop;
    logic    result;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic func_pop;
    logic empty;
    logic full;
    logic one_left;
    logic pos_zero;
    logic greater;
  } sts_t;

endpackage

// ===== hdl/smpq_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smpq_in_if
// Request channel: operation code and key, with valid and ready.
// ---------------------------------------------------------------------------
interface smpq_in_if;
  import smpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, func, key, input ready);
  modport sink (input valid, func, key, output ready);

endinterface

// ===== hdl/smpq_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smpq_out_if
// Response channel: head key, occupancy and status, with valid and ready.
// ---------------------------------------------------------------------------
interface smpq_out_if;
  import smpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] head_key;
  logic                    head_valid;
  logic [COUNT_W-1:0]      entry_count;
  logic [1:0]              status;

  modport source (output valid, head_key, head_valid, entry_count, status, input ready);
  modport sink (input valid, head_key, head_valid, entry_count, status, output ready);

endinterface

// ===== hdl/smpq_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smpq_datapath
// Circular key memory with base pointer, insertion shifter and output register.
// ---------------------------------------------------------------------------
module smpq_datapath #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  smpq_pkg::cmd_t cmd,
  output smpq_pkg::sts_t sts,
  smpq_in_if.sink        req,
  smpq_out_if.source     rsp
);
  import smpq_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] b, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(b) + (CW + 1)'(off);
    if (sum >= (CW + 1)'(CAPACITY)) begin
      sum = sum - (CW + 1)'(CAPACITY);
    end
    return PW'(sum);
  endfunction

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic [PW-1:0]           base;
  logic [CW-1:0]           count;
  logic [CW-1:0]           pos;
  logic                    func;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] head;
  logic signed [KEY_W-1:0] rd_data;
  logic [PW-1:0]           rd_addr;
  logic [PW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic                    out_valid;

  assign rd_addr = cmd.rd_head ? phys(base, CW'(1)) : phys(base, pos - CW'(1));
  assign wr_addr = phys(base, pos);
  assign wr_data = cmd.shift ? rd_data : key;

  assign req.ready    = cmd.in_ready;
  assign rsp.valid    = out_valid;

  assign sts.in_valid = req.valid;
  assign sts.out_free = !out_valid || rsp.ready;
  assign sts.func_pop = (func == FUNC_POP);
  assign sts.empty    = (count == '0);
  assign sts.full     = (count == CW'(CAPACITY));
  assign sts.one_left = (count == CW'(1));
  assign sts.pos_zero = (pos == '0);
  assign sts.greater  = (rd_data > key);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= req.func;
      key  <= req.key;
    end
    if (cmd.rd_prev || cmd.rd_head) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.shift || cmd.place) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.place && pos == '0) begin
      head <= key;
    end else if (cmd.pop) begin
      head <= rd_data;
    end
    if (cmd.result) begin
      rsp.head_key    <= (count != '0) ? head : '0;
      rsp.head_valid  <= (count != '0);
      rsp.entry_count <= COUNT_W'(count);
      rsp.status      <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      count     <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        pos <= count;
      end else if (cmd.shift) begin
        pos <= pos - CW'(1);
      end
      if (cmd.place) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count - CW'(1);
        base  <= phys(base, CW'(1));
      end
      if (cmd.result) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/smpq_controller.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smpq_controller
// Sequences push insertion, pop and the response for one transaction.
// ---------------------------------------------------------------------------
module smpq_controller (
  input  logic           clk,
  input  logic           rst,
  input  smpq_pkg::sts_t sts,
  output smpq_pkg::cmd_t cmd
);
  import smpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CMP,
    S_POPW,
    S_FIN
  } state_t;

  state_t  state;
  status_t status_q;

  always_comb begin
    cmd          = '0;
    cmd.status   = status_q;
    cmd.in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = sts.in_valid;
      end
      S_DECIDE: begin
        if (sts.func_pop) begin
          if (!sts.empty) begin
            if (sts.one_left) begin
              cmd.pop = 1'b1;
            end else begin
              cmd.rd_head = 1'b1;
            end
          end
        end else if (!sts.full) begin
          if (sts.pos_zero) begin
            cmd.place = 1'b1;
          end else begin
            cmd.rd_prev = 1'b1;
          end
        end
      end
      S_CMP: begin
        if (sts.greater) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.place = 1'b1;
        end
      end
      S_POPW: begin
        cmd.pop = 1'b1;
      end
      S_FIN: begin
        cmd.result = sts.out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= ST_DONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sts.in_valid) begin
            status_q <= ST_DONE;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (sts.func_pop) begin
            if (sts.empty) begin
              status_q <= ST_EMPTY;
              state    <= S_FIN;
            end else if (sts.one_left) begin
              state <= S_FIN;
            end else begin
              state <= S_POPW;
            end
          end else if (sts.full) begin
            status_q <= ST_FULL;
            state    <= S_FIN;
          end else if (sts.pos_zero) begin
            state <= S_FIN;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= sts.greater ? S_DECIDE : S_FIN;
        end
        S_POPW: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/sorted_min_priority_queue.sv =====
`timescale 1ns / 1ps
// A push moves each stored key that is greater than the new key up by one slot, starting
// from the tail; each of those costs one memory read and one memory write in the key
// memory. A push to a full queue is dropped with status FULL; a pop returns EMPTY status
// when the queue is empty. Transactions are handled one at a time: the next one can be
// accepted in the cycle after the response is loaded.
// Reset clears the count, base pointer and control; the key memory is not cleared.
// ---------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded minimum priority queue of signed keys kept in ascending order.
// ---------------------------------------------------------------------------
module sorted_min_priority_queue #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  smpq_in_if.sink    req,
  smpq_out_if.source rsp
);
  import smpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smpq_controller u_controller (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the sorted minimum priority queue against a queue-based predictor.
// The test starts with directed pushes and pops that cover the extreme keys,
// duplicates, a full queue and an empty queue. Bursts of random pushes and
// pops follow, with shifting push rates, under several patterns of sender
// gaps and receiver stalls. Every response is compared with the prediction.
// ---------------------------------------------------------------------------
module testbench;
  import smpq_pkg::*;

  localparam int QCAP        = CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS = 407;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 + 2 * QCAP + 8;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic                    func;
    logic signed [KEY_W-1:0] key;
  } queue_request_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] head_key;
    logic                    head_valid;
    logic [COUNT_W-1:0]      entry_count;
    status_t                 status;
  } queue_result_t;

  logic clk;
  logic rst;
  logic req_fire;
  idle_mode_t idle_mode;
  int mismatches;
  int quiet_cycles;

  queue_request_t pending_requests[$];
  queue_result_t expected_results[$];
  logic signed [KEY_W-1:0] held_keys[$];

  smpq_in_if req();
  smpq_out_if rsp();

  sorted_min_priority_queue #(.CAPACITY(QCAP)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic queue_result_t apply_request(logic func, logic signed [KEY_W-1:0] key);
    queue_result_t r;
    int pos;
    r.status = ST_DONE;
    if (func == FUNC_POP) begin
      if (held_keys.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        void'(held_keys.pop_front());
      end
    end else if (held_keys.size() >= QCAP) begin
      r.status = ST_FULL;
    end else begin
      pos = 0;
      while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
      held_keys.insert(pos, key);
    end
    r.head_valid = held_keys.size() != 0;
    r.head_key = r.head_valid ? held_keys[0] : '0;
    r.entry_count = COUNT_W'(held_keys.size());
    return r;
  endfunction

  function automatic logic sender_idle();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 54;
      IDLE_BOTH:   return $urandom_range(99) < 20;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 54;
      IDLE_BOTH:     return $urandom_range(99) < 20;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $signed(32'($urandom_range(16))) - 32'sd8;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  task automatic add_request(logic func, logic signed [KEY_W-1:0] key);
    queue_request_t item;
    item.func = func;
    item.key = key;
    pending_requests.push_back(item);
  endtask

  task automatic add_random_requests(int count);
    int push_pct;
    push_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n == 0 || $urandom_range(24) == 0) begin
        case ($urandom_range(3))
          0: push_pct = 25;
          1: push_pct = 50;
          2: push_pct = 75;
          default: push_pct = 90;
        endcase
      end
      add_request(($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP, pick_key());
    end
  endtask

  always @(negedge clk) begin
    queue_request_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
      rsp.ready <= 1'b0;
    end else begin
      if (!req.valid || req_fire) begin
        if (pending_requests.size() != 0 && !sender_idle()) begin
          nxt = pending_requests.pop_front();
          req.valid <= 1'b1;
          req.func <= nxt.func;
          req.key <= nxt.key;
        end else begin
          req.valid <= 1'b0;
        end
      end
      rsp.ready <= !receiver_stall();
    end
  end

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst) begin
      req_fire <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_fire <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_request(req.func, req.key));
      end
      if (rsp.valid && rsp.ready) begin
        got.head_key = rsp.head_key;
        got.head_valid = rsp.head_valid;
        got.entry_count = rsp.entry_count;
        got.status = status_t'(rsp.status);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected response key=%0d valid=%0b count=%0d status=%0d",
                     $realtime, got.head_key, got.head_valid, got.entry_count, got.status);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: response mismatch expected key=%0d valid=%0b count=%0d status=%0d",
                       $realtime, want.head_key, want.head_valid, want.entry_count,
                       want.status);
              $display("%0t:                   actual key=%0d valid=%0b count=%0d status=%0d",
                       $realtime, got.head_key, got.head_valid, got.entry_count,
                       got.status);
            end
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    idle_mode_t phase_modes[4];
    phase_modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    clk = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.func = FUNC_PUSH;
    req.key = '0;
    rsp.ready = 1'b0;
    idle_mode = IDLE_NONE;
    mismatches = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    add_request(FUNC_POP, 32'sd0);
    add_request(FUNC_PUSH, 32'sh7fff_ffff);
    add_request(FUNC_PUSH, 32'sh8000_0000);
    add_request(FUNC_PUSH, 32'sd0);
    add_request(FUNC_PUSH, -32'sd1);
    add_request(FUNC_PUSH, 32'sd1);
    add_request(FUNC_PUSH, 32'sd5);
    add_request(FUNC_PUSH, 32'sd5);
    add_request(FUNC_PUSH, 32'sd5);
    add_request(FUNC_PUSH, 32'sd3);
    add_request(FUNC_PUSH, 32'sd100);
    add_request(FUNC_PUSH, -32'sd100);
    add_request(FUNC_PUSH, 32'sh8000_0001);
    add_request(FUNC_PUSH, 32'sh7fff_fffe);
    add_request(FUNC_PUSH, 32'sd5);
    add_request(FUNC_PUSH, 32'sd2);
    add_request(FUNC_PUSH, 32'sd0);
    add_request(FUNC_PUSH, 32'sh8000_0000);
    add_request(FUNC_PUSH, 32'sh7fff_ffff);
    add_request(FUNC_POP, 32'sh7fff_ffff);
    add_request(FUNC_POP, 32'sh8000_0000);
    add_request(FUNC_POP, -32'sd1);

    foreach (phase_modes[p]) begin
      wait (pending_requests.size() == 0);
      idle_mode = phase_modes[p];
      add_random_requests(RANDOM_ITEMS);
    end

    wait (pending_requests.size() == 0 && req.valid == 1'b0);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_results.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sorted_min_priority_queue.f =====
hdl/smpq_pkg.sv
hdl/smpq_in_if.sv
hdl/smpq_out_if.sv
hdl/smpq_datapath.sv
hdl/smpq_controller.sv
hdl/sorted_min_priority_queue.sv
sim/testbench.sv
